### rtl/core/ulpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpp_pkg
// Shared types and character codes of the unsolicited line parameter parser.
// ----------------------------------------------------------------------------
package ulpp_pkg;

  localparam int CNT_W = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_LEAD,
    PH_SEP,
    PH_INT,
    PH_STR,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_PARAM,
    KIND_SUMMARY
  } kind_t;

  typedef enum logic [1:0] {
    TYPE_NONE,
    TYPE_INT,
    TYPE_STR
  } ptype_t;

  // results caused by one character, in delivery order a, b, c, d, e
  typedef struct packed {
    logic             a_valid;
    logic [CNT_W-1:0] a_idx;
    logic             a_neg;
    logic [31:0]      a_acc;
    logic             b_valid;
    logic [CNT_W-1:0] b_idx;
    logic             b_stored;
    logic [CNT_W-1:0] c_lo;
    logic [CNT_W-1:0] c_hi;
    logic             d_valid;
    logic             d_int;
    logic [CNT_W-1:0] d_idx;
    logic             d_neg;
    logic [31:0]      d_acc;
    logic             e_valid;
    logic [CNT_W-1:0] e_total;
  } plan_t;

endpackage

### rtl/core/ulpp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpp_in_if
// Character channel: one line character and its end-of-line mark.
// ----------------------------------------------------------------------------
interface ulpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

### rtl/core/ulpp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpp_out_if
// Result channel: string bytes, parameter records and line summaries.
// ----------------------------------------------------------------------------
interface ulpp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic [2:0]         param_index;
  logic [1:0]         param_type;
  logic signed [31:0] int_value;
  logic [7:0]         string_byte;
  logic [3:0]         string_length;
  logic               string_stored;
  logic [3:0]         param_total;
  logic               last;

  modport source (
    output valid, output record_kind, output param_index, output param_type,
    output int_value, output string_byte, output string_length,
    output string_stored, output param_total, output last, input ready
  );
  modport sink (
    input valid, input record_kind, input param_index, input param_type,
    input int_value, input string_byte, input string_length,
    input string_stored, input param_total, input last, output ready
  );
endinterface

### rtl/core/ulpp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpp_store
// String buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ulpp_store #(
  parameter int STRING_CAPACITY = 16,
  localparam int AW = $clog2(STRING_CAPACITY)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [STRING_CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/ulpp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpp_parse
// Line parse state and the set of results caused by each character.
// ----------------------------------------------------------------------------
module ulpp_parse import ulpp_pkg::*; #(
  parameter int MAX_PARAMS = 8,
  parameter int STRING_CAPACITY = 16,
  localparam int SC_W = $clog2(STRING_CAPACITY + 1),
  localparam int AW = $clog2(STRING_CAPACITY)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic            end_of_line,
  output plan_t           plan,
  output logic [SC_W-1:0] plan_scount,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARAMS);
  localparam logic [SC_W-1:0] CAP = SC_W'(STRING_CAPACITY);

  phase_t           phase, phase_mid, phase_next;
  logic [CNT_W-1:0] cnt, cnt_mid, cnt_next;
  logic [31:0]      acc, acc_mid, acc_next;
  logic             neg, neg_mid, neg_next;
  logic [SC_W-1:0]  scount, scount_mid, scount_next;
  logic             do_start;
  logic             fill;
  logic [CNT_W-1:0] start_k;
  logic             is_digit;
  logic             is_sep;
  logic [31:0]      digit;

  assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
  assign is_sep   = (char_code == CH_SPACE) || (char_code == CH_COMMA);
  assign digit    = {28'd0, char_code[3:0]};

  assign wr_addr = scount[AW-1:0];
  assign wr_data = char_code;

  // next state
  always_comb begin
    phase_mid  = phase;
    cnt_mid    = cnt;
    acc_mid    = acc;
    neg_mid    = neg;
    scount_mid = scount;
    do_start   = 1'b0;
    fill       = 1'b0;
    start_k    = cnt;
    wr_en      = 1'b0;
    if (char_code == CH_NUL) begin
      if (phase == PH_INT || phase == PH_STR) begin
        cnt_mid = cnt + CNT_W'(1);
      end
      phase_mid = PH_DONE;
    end else begin
      case (phase)
        PH_SEEK: begin
          if (char_code == CH_COLON) begin
            phase_mid = PH_LEAD;
          end
        end
        PH_LEAD: begin
          if (char_code != CH_SPACE) begin
            do_start = 1'b1;
          end
        end
        PH_SEP: begin
          if (!is_sep) begin
            do_start = 1'b1;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            acc_mid = (acc << 3) + (acc << 1) + digit;
          end else begin
            cnt_mid = cnt + CNT_W'(1);
            if (cnt_mid >= MAX_CNT) begin
              phase_mid = PH_DONE;
            end else begin
              phase_mid = PH_SEP;
              start_k   = cnt_mid;
              do_start  = !is_sep;
            end
          end
        end
        PH_STR: begin
          if (char_code == CH_QUOTE) begin
            cnt_mid   = cnt + CNT_W'(1);
            phase_mid = (cnt_mid >= MAX_CNT) ? PH_DONE : PH_SEP;
          end else if (scount < CAP) begin
            wr_en      = accept;
            scount_mid = scount + SC_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (do_start) begin
        if (char_code == CH_QUOTE) begin
          scount_mid = '0;
          phase_mid  = PH_STR;
        end else if (is_digit || char_code == CH_MINUS) begin
          neg_mid   = (char_code == CH_MINUS);
          acc_mid   = (char_code == CH_MINUS) ? 32'd0 : digit;
          phase_mid = PH_INT;
        end else begin
          fill      = 1'b1;
          cnt_mid   = MAX_CNT;
          phase_mid = PH_DONE;
        end
      end
    end
    if (end_of_line) begin
      phase_next  = PH_SEEK;
      cnt_next    = '0;
      acc_next    = '0;
      neg_next    = 1'b0;
      scount_next = '0;
    end else begin
      phase_next  = phase_mid;
      cnt_next    = cnt_mid;
      acc_next    = acc_mid;
      neg_next    = neg_mid;
      scount_next = scount_mid;
    end
  end

  // results of this character
  always_comb begin
    plan        = '0;
    plan_scount = scount;
    if (char_code != CH_NUL && phase == PH_INT && !is_digit) begin
      plan.a_valid = 1'b1;
      plan.a_idx   = cnt;
      plan.a_acc   = acc;
      plan.a_neg   = neg;
    end
    if (char_code != CH_NUL && phase == PH_STR && char_code == CH_QUOTE) begin
      plan.b_valid  = 1'b1;
      plan.b_idx    = cnt;
      plan.b_stored = (scount < CAP);
    end
    if (fill) begin
      plan.c_lo = start_k;
      plan.c_hi = MAX_CNT;
    end
    if (char_code == CH_NUL && (phase == PH_INT || phase == PH_STR)) begin
      plan.d_valid = 1'b1;
      plan.d_int   = (phase == PH_INT);
      plan.d_idx   = cnt;
      plan.d_acc   = acc;
      plan.d_neg   = neg;
    end else if (end_of_line && (phase_mid == PH_INT || phase_mid == PH_STR)) begin
      plan.d_valid = 1'b1;
      plan.d_int   = (phase_mid == PH_INT);
      plan.d_idx   = cnt_mid;
      plan.d_acc   = acc_mid;
      plan.d_neg   = neg_mid;
    end
    if (end_of_line) begin
      plan.e_valid = 1'b1;
      plan.e_total = (phase_mid == PH_INT || phase_mid == PH_STR) ?
                     cnt_mid + CNT_W'(1) : cnt_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SEEK;
      cnt    <= '0;
      acc    <= '0;
      neg    <= 1'b0;
      scount <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      acc    <= acc_next;
      neg    <= neg_next;
      scount <= scount_next;
    end
  end

endmodule

### rtl/core/ulpp_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpp_emit
// Holds the pending results of one character and releases one per cycle
// into the result register while that register is empty or being read.
// ----------------------------------------------------------------------------
module ulpp_emit import ulpp_pkg::*; #(
  parameter int STRING_CAPACITY = 16,
  localparam int SC_W = $clog2(STRING_CAPACITY + 1),
  localparam int AW = $clog2(STRING_CAPACITY)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  plan_t           plan_in,
  input  logic [SC_W-1:0] scount_in,
  output logic            in_ready,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  ulpp_out_if.source      rec_out
);

  plan_t           plan, plan_next;
  logic [SC_W-1:0] bcount;
  logic [SC_W-1:0] bpos, bpos_next;
  logic            busy, more, load;

  kind_t       p_kind;
  logic [2:0]  p_idx;
  ptype_t      p_type;
  logic [31:0] p_val;
  logic [31:0] sel_acc;
  logic        sel_neg;
  logic [3:0]  p_len;
  logic        p_stored;
  logic [3:0]  p_total;
  logic        p_byte;

  logic        out_valid;
  kind_t       o_kind;
  logic [2:0]  o_idx;
  ptype_t      o_type;
  logic [31:0] o_val;
  logic [3:0]  o_len;
  logic        o_stored;
  logic [3:0]  o_total;
  logic        o_last;
  logic        o_byte;

  always_comb begin
    plan_next = plan;
    bpos_next = bpos;
    p_kind    = KIND_SUMMARY;
    p_idx     = '0;
    p_type    = TYPE_NONE;
    sel_acc   = '0;
    sel_neg   = 1'b0;
    p_len     = '0;
    p_stored  = 1'b0;
    p_total   = '0;
    p_byte    = 1'b0;
    if (plan.a_valid) begin
      p_kind            = KIND_PARAM;
      p_idx             = 3'(plan.a_idx);
      p_type            = TYPE_INT;
      sel_acc           = plan.a_acc;
      sel_neg           = plan.a_neg;
      plan_next.a_valid = 1'b0;
    end else if (plan.b_valid) begin
      p_idx  = 3'(plan.b_idx);
      p_type = TYPE_STR;
      if (plan.b_stored && bpos < bcount) begin
        p_kind    = KIND_BYTE;
        p_byte    = 1'b1;
        bpos_next = bpos + SC_W'(1);
      end else begin
        p_kind            = KIND_PARAM;
        p_len             = plan.b_stored ? 4'(bcount) : 4'd0;
        p_stored          = plan.b_stored;
        plan_next.b_valid = 1'b0;
      end
    end else if (plan.c_lo != plan.c_hi) begin
      p_kind         = KIND_PARAM;
      p_idx          = 3'(plan.c_lo);
      plan_next.c_lo = plan.c_lo + CNT_W'(1);
    end else if (plan.d_valid) begin
      p_kind            = KIND_PARAM;
      p_idx             = 3'(plan.d_idx);
      p_type            = plan.d_int ? TYPE_INT : TYPE_NONE;
      sel_acc           = plan.d_int ? plan.d_acc : 32'd0;
      sel_neg           = plan.d_int && plan.d_neg;
      plan_next.d_valid = 1'b0;
    end else if (plan.e_valid) begin
      p_total           = plan.e_total;
      plan_next.e_valid = 1'b0;
    end
    p_val = sel_neg ? (32'd0 - sel_acc) : sel_acc;
  end

  assign busy = plan.a_valid || plan.b_valid || (plan.c_lo != plan.c_hi) ||
                plan.d_valid || plan.e_valid;
  assign more = plan_next.a_valid || plan_next.b_valid ||
                (plan_next.c_lo != plan_next.c_hi) ||
                plan_next.d_valid || plan_next.e_valid;
  assign load     = busy && (!out_valid || rec_out.ready);
  assign in_ready = !busy || (load && !more);
  assign rd_en    = load && p_byte;
  assign rd_addr  = bpos[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      plan <= '0;
      bpos <= '0;
    end else if (accept) begin
      plan <= plan_in;
      bpos <= '0;
    end else if (load) begin
      plan <= plan_next;
      bpos <= bpos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bcount <= scount_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rec_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_kind   <= p_kind;
      o_idx    <= p_idx;
      o_type   <= p_type;
      o_val    <= p_val;
      o_len    <= p_len;
      o_stored <= p_stored;
      o_total  <= p_total;
      o_last   <= !more;
      o_byte   <= p_byte;
    end
  end

  assign rec_out.valid         = out_valid;
  assign rec_out.record_kind   = o_kind;
  assign rec_out.param_index   = o_idx;
  assign rec_out.param_type    = o_type;
  assign rec_out.int_value     = o_val;
  assign rec_out.string_byte   = o_byte ? rd_data : 8'd0;
  assign rec_out.string_length = o_len;
  assign rec_out.string_stored = o_stored;
  assign rec_out.param_total   = o_total;
  assign rec_out.last          = o_last;

endmodule

### rtl/core/unsolicited_line_param_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsolicited_line_param_parser
// Each result is registered in the pending results, then in the result register.
// Throughput: 1 character per cycle while each causes at most one result and
// rec_out does not stall; a character causing more results holds char_in until
// its last result is loaded into the result register.
// Reset (rst, synchronous): parser back to seeking the colon, pending results
// and result register emptied; the string buffer is not cleared.
// ----------------------------------------------------------------------------
module unsolicited_line_param_parser import ulpp_pkg::*; #(
  parameter int MAX_PARAMS = 8,
  parameter int STRING_CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  ulpp_in_if.sink    char_in,
  ulpp_out_if.source rec_out
);

  localparam int SC_W = $clog2(STRING_CAPACITY + 1);
  localparam int AW = $clog2(STRING_CAPACITY);

  plan_t           plan;
  logic [SC_W-1:0] plan_scount;
  logic            in_ready;
  logic            accept;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;

  assign accept        = char_in.valid && in_ready;
  assign char_in.ready = in_ready;

  ulpp_parse #(
    .MAX_PARAMS(MAX_PARAMS),
    .STRING_CAPACITY(STRING_CAPACITY)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .char_code(char_in.char_code),
    .end_of_line(char_in.end_of_line),
    .plan(plan),
    .plan_scount(plan_scount),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  ulpp_store #(
    .STRING_CAPACITY(STRING_CAPACITY)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ulpp_emit #(
    .STRING_CAPACITY(STRING_CAPACITY)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .plan_in(plan),
    .scount_in(plan_scount),
    .in_ready(in_ready),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .rec_out(rec_out)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the unsolicited line parameter parser. Lines of characters are
// sent over the character channel with random gaps while the result channel
// stalls at random. A line-level parser model in a scoreboard class predicts
// every string byte, parameter record and line summary, and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ulpp_pkg::*;

  localparam int MAX_PARAMS   = 8;
  localparam int STR_CAP      = 16;
  localparam int RANDOM_ITEMS = 380;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef logic [7:0] chars_t[$];

  typedef struct {
    kind_t              kind;
    logic [2:0]         idx;
    ptype_t             ptype;
    logic signed [31:0] ival;
    logic [7:0]         sbyte;
    logic [3:0]         slen;
    logic               stored;
    logic [3:0]         total;
    logic               last;
  } rec_t;

  class line_parse_board;
    phase_t      phase;
    int unsigned count;
    logic [31:0] acc;
    bit          neg;
    logic [7:0]  store[STR_CAP];
    int unsigned slen;
    rec_t        pending[$];
    int          errors;
    int          chars_noted;
    int          lines_noted;
    int          records_checked;
    int          bytes_checked;

    function new();
      phase = PH_SEEK;
      count = 0;
      acc = '0;
      neg = 1'b0;
      slen = 0;
      errors = 0;
      chars_noted = 0;
      lines_noted = 0;
      records_checked = 0;
      bytes_checked = 0;
    endfunction

    function void add_rec(kind_t k, int unsigned idx, ptype_t t, logic [31:0] v,
                          logic [7:0] b, int unsigned len, bit st, int unsigned tot);
      rec_t r;
      r.kind = k;
      r.idx = idx[2:0];
      r.ptype = t;
      r.ival = v;
      r.sbyte = b;
      r.slen = len[3:0];
      r.stored = st;
      r.total = tot[3:0];
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void finish_param();
      count++;
      phase = (count >= MAX_PARAMS) ? PH_DONE : PH_SEP;
    endfunction

    function void add_int();
      add_rec(KIND_PARAM, count, TYPE_INT, neg ? 32'd0 - acc : acc, 0, 0, 0, 0);
    endfunction

    function void start_param(logic [7:0] c);
      if (c == CH_QUOTE) begin
        slen = 0;
        phase = PH_STR;
      end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        acc = (c == CH_MINUS) ? 32'd0 : 32'(c - CH_ZERO);
        phase = PH_INT;
      end else begin
        while (count < MAX_PARAMS) begin
          add_rec(KIND_PARAM, count, TYPE_NONE, 0, 0, 0, 0, 0);
          count++;
        end
        phase = PH_DONE;
      end
    endfunction

    // record the open parameter when parsing ends
    function void close_open();
      if (phase == PH_INT) begin
        add_int();
        count++;
      end else if (phase == PH_STR) begin
        add_rec(KIND_PARAM, count, TYPE_NONE, 0, 0, 0, 0, 0);
        count++;
      end
      phase = PH_DONE;
    endfunction

    function void take_char(logic [7:0] c);
      if (c == CH_NUL) begin
        close_open();
        return;
      end
      case (phase)
        PH_SEEK: begin
          if (c == CH_COLON) phase = PH_LEAD;
        end
        PH_LEAD: begin
          if (c != CH_SPACE) start_param(c);
        end
        PH_SEP: begin
          if (c != CH_SPACE && c != CH_COMMA) start_param(c);
        end
        PH_INT: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = acc * 32'd10 + 32'(c - CH_ZERO);
          end else begin
            add_int();
            finish_param();
            if (phase == PH_SEP && c != CH_SPACE && c != CH_COMMA) start_param(c);
          end
        end
        PH_STR: begin
          if (c == CH_QUOTE) begin
            if (slen < STR_CAP) begin
              for (int i = 0; i < slen; i++)
                add_rec(KIND_BYTE, count, TYPE_STR, 0, store[i], 0, 0, 0);
              add_rec(KIND_PARAM, count, TYPE_STR, 0, 0, slen, 1, 0);
            end else begin
              add_rec(KIND_PARAM, count, TYPE_STR, 0, 0, 0, 0, 0);
            end
            finish_param();
          end else if (slen < STR_CAP) begin
            store[slen] = c;
            slen++;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic eol);
      int first;
      first = pending.size();
      chars_noted++;
      take_char(c);
      if (eol) begin
        close_open();
        add_rec(KIND_SUMMARY, 0, TYPE_NONE, 0, 0, 0, 0, count);
        phase = PH_SEEK;
        count = 0;
        acc = '0;
        neg = 1'b0;
        slen = 0;
        lines_noted++;
      end
      if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void cmp(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_record(logic [1:0] kind, logic [2:0] idx, logic [1:0] ptype,
                               logic [31:0] ival, logic [7:0] sbyte, logic [3:0] slen_a,
                               logic stored, logic [3:0] total, logic last);
      rec_t e;
      if (pending.size() == 0) begin
        $display("%0t ns: unexpected record, expected none, actual kind %0d index %0d",
                 $time, kind, idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      records_checked++;
      if (e.kind == KIND_BYTE) bytes_checked++;
      cmp("record_kind", 32'(e.kind), 32'(kind));
      cmp("param_index", 32'(e.idx), 32'(idx));
      cmp("param_type", 32'(e.ptype), 32'(ptype));
      cmp("int_value", e.ival, ival);
      cmp("string_byte", 32'(e.sbyte), 32'(sbyte));
      cmp("string_length", 32'(e.slen), 32'(slen_a));
      cmp("string_stored", 32'(e.stored), 32'(stored));
      cmp("param_total", 32'(e.total), 32'(total));
      cmp("last", 32'(e.last), 32'(last));
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   items_sent = 0;
  line_parse_board board = new();

  ulpp_in_if  char_if();
  ulpp_out_if rec_if();

  unsolicited_line_param_parser #(
    .MAX_PARAMS(MAX_PARAMS),
    .STRING_CAPACITY(STR_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .char_in(char_if),
    .rec_out(rec_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d records outstanding", $time, board.outstanding());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (char_if.valid && char_if.ready)
        board.note_char(char_if.char_code, char_if.end_of_line);
      if (rec_if.valid && rec_if.ready)
        board.check_record(rec_if.record_kind, rec_if.param_index, rec_if.param_type,
                           rec_if.int_value, rec_if.string_byte, rec_if.string_length,
                           rec_if.string_stored, rec_if.param_total, rec_if.last);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side stalls
  initial begin
    int on_len;
    int off_len;
    rec_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      off_len = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      rec_if.ready = 1'b1;
      repeat (on_len) @(negedge clk);
      if (off_len > 0) begin
        rec_if.ready = 1'b0;
        repeat (off_len) @(negedge clk);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic eol, int gap);
    if (gap > 0) begin
      @(negedge clk);
      char_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_if.valid = 1'b1;
    char_if.char_code = c;
    char_if.end_of_line = eol;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line(ref chars_t line);
    bit burst;
    burst = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < line.size(); i++)
      send_char(line[i], i == line.size() - 1, burst ? 0 : pick_gap());
  endtask

  task automatic drain();
    @(negedge clk);
    char_if.valid = 1'b0;
    while (board.outstanding() > 0) @(negedge clk);
  endtask

  task automatic add_text(ref chars_t line, input string s);
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_content();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  task automatic build_line(ref chars_t line);
    int r;
    int n;
    int nparams;
    int kind;
    logic [7:0] c;
    line.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 12);
      repeat (n) line.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(0, 4);
    repeat (n) line.push_back(8'($urandom_range(8'h41, 8'h5A)));
    if (r >= 12) line.push_back(CH_COLON);
    n = $urandom_range(0, 2);
    repeat (n) line.push_back(CH_SPACE);
    nparams = ($urandom_range(0, 99) < 12) ? $urandom_range(8, 10) : $urandom_range(1, 4);
    for (int p = 0; p < nparams; p++) begin
      if (p > 0) begin
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) line.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SPACE);
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        if ($urandom_range(0, 2) == 0) line.push_back(CH_MINUS);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
        if (n == 0 && line[line.size() - 1] != CH_MINUS) n = 1;
        repeat (n) line.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 90) begin
        line.push_back(CH_QUOTE);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        repeat (n) line.push_back(pick_content());
        if (!(p == nparams - 1 && $urandom_range(0, 19) == 0)) line.push_back(CH_QUOTE);
      end else begin
        do c = 8'($urandom_range(1, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_QUOTE ||
               c == CH_SPACE || c == CH_COMMA);
        line.push_back(c);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      line.push_back(CH_NUL);
      n = $urandom_range(0, 3);
      repeat (n) line.push_back(8'($urandom_range(0, 255)));
    end else if (r < 14) begin
      n = $urandom_range(1, 3);
      repeat (n) line.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    chars_t line;
    int directed_items;
    char_if.valid = 1'b0;
    char_if.char_code = '0;
    char_if.end_of_line = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no colon, top character code
    line.delete();
    line.push_back(8'hFF);
    send_line(line);
    // comma right after the colon
    line.delete();
    add_text(line, ":,");
    send_line(line);
    // minus with no digits
    line.delete();
    add_text(line, ":-");
    send_line(line);
    // quote left open at line end
    line.delete();
    add_text(line, ":\"a");
    send_line(line);
    // zero character ends parsing
    line.delete();
    add_text(line, ":7");
    line.push_back(CH_NUL);
    add_text(line, "x");
    send_line(line);
    line.delete();
    add_text(line, ":\"hi\" -5");
    send_line(line);
    drain();
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) begin
      build_line(line);
      send_line(line);
      if ($urandom_range(0, 99) < 15) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d lines, %0d characters, %0d records checked (%0d string bytes)",
             board.lines_noted, board.chars_noted, board.records_checked,
             board.bytes_checked);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
